@@ hw/rtl/ocpt_pkg.sv @@
// ----------------------------------------------------------------------------
// ocpt_pkg
// Shared types and constants of the overlap chain portion trimmer.
// ----------------------------------------------------------------------------
package ocpt_pkg;

  localparam int unsigned CovW   = 16;
  localparam int unsigned IdW    = 40;
  localparam int unsigned KW     = 5;
  localparam int unsigned LinkW  = 16;
  localparam int unsigned IdxW   = 24;
  localparam int unsigned OutOffW = 32;
  localparam logic [KW-1:0] KReset = 5'd10;

  typedef struct packed {
    logic [CovW-1:0]  coverage;
    logic [IdW-1:0]   vertex_id;
    logic [KW-1:0]    overlap_to_next;
    logic [LinkW-1:0] link_bases;
    logic             last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]    vertex_index;
    logic [OutOffW-1:0] vertex_offset;
    logic [KW-1:0]      portion_begin;
    logic [KW-1:0]      portion_end;
    logic               last_result;
  } out_item_t;

  function automatic logic stronger(logic [CovW-1:0] ca, logic [IdW-1:0] ia,
                                    logic [CovW-1:0] cb, logic [IdW-1:0] ib);
    return (ca > cb) || ((ca == cb) && (ia < ib));
  endfunction

endpackage

@@ hw/rtl/ocpt_if.sv @@
// ----------------------------------------------------------------------------
// ocpt_in_if / ocpt_out_if / ocpt_cfg_if
// Valid/ready channels of the trimmer.
// ----------------------------------------------------------------------------
interface ocpt_in_if;
  logic valid;
  logic ready;
  ocpt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ocpt_out_if;
  logic valid;
  logic ready;
  ocpt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ocpt_cfg_if;
  logic valid;
  logic ready;
  logic [ocpt_pkg::KW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/overlap_chain_portion_trimmer_unit.sv @@
// ----------------------------------------------------------------------------
// overlap_chain_portion_trimmer_unit
// Sequenced window scan that trims chain markers against stronger neighbors.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  in_ch     sink       one marker
//  out_ch    source     one trimmed range
//  cfg_ch    sink       marker_length write
// Every window entry visit has two phases: issue the address, then use the registered read.
// One marker runs a look-back scan, a forward scan of the pending entries, the emit of
// settled ranges and the write of its own entry.
// A chain end or a full window adds a flush that settles or emits held entries.
// Output stalls hold the emit sequence; input is not ready until the marker is done.
// Reset clears the control registers and sets marker_length to KReset; window entries are undefined until written.
// ----------------------------------------------------------------------------
module overlap_chain_portion_trimmer_unit #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned OFFSET_BITS  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ocpt_in_if.sink    in_ch,
  ocpt_out_if.source out_ch,
  ocpt_cfg_if.sink   cfg_ch
);
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned KW = ocpt_pkg::KW;

  localparam logic [2:0] S_IDLE = 3'd0, S_BACK = 3'd1, S_FWD = 3'd2,
                         S_EMIT = 3'd3, S_WRITE = 3'd4, S_FLUSH = 3'd5;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [ocpt_pkg::CovW-1:0] cov;
    logic [ocpt_pkg::IdW-1:0] id;
    logic [KW-1:0] bgn;
    logic [KW-1:0] fin;
    logic settled;
    logic [ocpt_pkg::IdxW-1:0] idx;
    logic last;
  } entry_t;

  entry_t mem_q [WINDOW_DEPTH];
  entry_t rd_q;

  logic [2:0] state_q, state_d;
  logic [KW-1:0] k_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q, done_q, n_q;
  logic [OFFSET_BITS-1:0] next_off_q;
  logic [ocpt_pkg::IdxW-1:0] cnt_q;
  ocpt_pkg::in_item_t item_q;
  logic [KW-1:0] kcur_q, begin_q;
  logic ph_q;

  logic [KW-1:0] k_eff;
  assign k_eff = (k_q == '0) ? KW'(1) : k_q;

  function automatic logic [AW-1:0] slot(logic [AW-1:0] h, logic [FW-1:0] n);
    logic [FW:0] s;
    s = (FW+1)'(h) + (FW+1)'(n);
    if (s >= (FW+1)'(WINDOW_DEPTH)) s = s - (FW+1)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] rd_addr;
  logic [FW-1:0] back_n;
  logic [OFFSET_BITS-1:0] gap;
  logic in_reach, back_win, fwd_win;
  assign back_n = n_q - FW'(1);
  always_comb begin
    if (state_q == S_BACK) rd_addr = slot(head_q, back_n);
    else if (state_q == S_EMIT || state_q == S_FLUSH) rd_addr = slot(head_q, done_q);
    else rd_addr = slot(head_q, n_q);
  end
  assign gap = next_off_q - rd_q.off;
  assign in_reach = gap <= OFFSET_BITS'(kcur_q);
  assign back_win = ocpt_pkg::stronger(rd_q.cov, rd_q.id, item_q.coverage, item_q.vertex_id);
  assign fwd_win = ocpt_pkg::stronger(item_q.coverage, item_q.vertex_id, rd_q.cov, rd_q.id);

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_q == S_IDLE);

  logic emit_ok, settle_now, fire;
  assign emit_ok = (done_q < fill_q) && rd_q.settled;
  assign out_ch.valid = (state_q == S_EMIT || state_q == S_FLUSH) && ph_q && emit_ok;
  assign fire = out_ch.valid && out_ch.ready;
  assign settle_now = (state_q == S_FLUSH) && ph_q && !emit_ok && (done_q < fill_q) &&
                      (item_q.last_vertex || done_q == '0);

  always_comb begin
    out_ch.data.vertex_index = rd_q.idx;
    out_ch.data.vertex_offset = ocpt_pkg::OutOffW'({{64{1'b0}}, rd_q.off});
    if (rd_q.fin <= rd_q.bgn) begin
      out_ch.data.portion_begin = '0;
      out_ch.data.portion_end = '0;
    end else begin
      out_ch.data.portion_begin = rd_q.bgn;
      out_ch.data.portion_end = rd_q.fin;
    end
    out_ch.data.last_result = rd_q.last;
  end

  logic [KW-1:0] ov_cl;
  logic [OFFSET_BITS-1:0] step;
  always_comb begin
    ov_cl = (item_q.overlap_to_next > kcur_q - KW'(1)) ? kcur_q - KW'(1)
                                                       : item_q.overlap_to_next;
    if (item_q.overlap_to_next != '0) step = OFFSET_BITS'(kcur_q - ov_cl);
    else step = OFFSET_BITS'(kcur_q) + OFFSET_BITS'(item_q.link_bases);
  end

  logic [AW-1:0] wr_slot;
  logic [FW-1:0] fill_nx, done_nx;
  logic drop;
  assign drop = fill_q >= FW'(WINDOW_DEPTH);
  assign wr_slot = drop ? head_q : slot(head_q, fill_q);
  assign fill_nx = drop ? fill_q : fill_q + FW'(1);
  assign done_nx = (drop && done_q != '0) ? done_q - FW'(1) : done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_ch.valid) state_d = S_BACK;
      S_BACK: if (n_q == '0 || (ph_q && (!in_reach || back_win))) state_d = S_FWD;
      S_FWD: if (n_q >= fill_q) state_d = S_EMIT;
      S_EMIT: if (ph_q && !emit_ok) state_d = S_WRITE;
      S_WRITE: state_d = (item_q.last_vertex ||
                          (fill_nx == FW'(WINDOW_DEPTH) && done_nx == '0))
                         ? S_FLUSH : S_IDLE;
      S_FLUSH: if (ph_q && !emit_ok && !settle_now) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = rd_addr;
    wr_data = rd_q;
    wr_data.settled = 1'b1;
    if (state_q == S_WRITE) begin
      wr_en = 1'b1;
      wr_addr = wr_slot;
      wr_data = '{off: next_off_q, cov: item_q.coverage, id: item_q.vertex_id,
                  bgn: begin_q, fin: kcur_q, settled: 1'b0, idx: cnt_q,
                  last: item_q.last_vertex};
    end else if (state_q == S_FWD && ph_q && (n_q < fill_q) && !rd_q.settled &&
                 (!in_reach || fwd_win)) begin
      wr_en = 1'b1;
      if (in_reach) wr_data.fin = gap[KW-1:0];
    end else if (settle_now) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q <= ocpt_pkg::KReset;
      head_q <= '0;
      fill_q <= '0;
      done_q <= '0;
      n_q <= '0;
      next_off_q <= '0;
      cnt_q <= '0;
      kcur_q <= '0;
      begin_q <= '0;
      ph_q <= 1'b0;
      item_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid) k_q <= cfg_ch.data;
      unique case (state_q)
        S_IDLE: if (in_ch.valid) begin
          item_q <= in_ch.data;
          kcur_q <= k_eff;
          begin_q <= '0;
          n_q <= fill_q;
          ph_q <= 1'b0;
        end
        S_BACK: begin
          if (state_d == S_FWD) begin
            if (n_q != '0 && in_reach && back_win) begin_q <= kcur_q - gap[KW-1:0];
            n_q <= done_q;
            ph_q <= 1'b0;
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            n_q <= back_n;
            ph_q <= 1'b0;
          end
        end
        S_FWD: begin
          if (n_q >= fill_q) ph_q <= 1'b0;
          else if (!ph_q) ph_q <= 1'b1;
          else begin
            n_q <= n_q + FW'(1);
            ph_q <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!ph_q) ph_q <= 1'b1;
          else if (fire) begin
            done_q <= done_q + FW'(1);
            ph_q <= 1'b0;
          end
        end
        S_WRITE: begin
          if (drop) head_q <= slot(head_q, FW'(1));
          fill_q <= fill_nx;
          done_q <= done_nx;
          cnt_q <= cnt_q + ocpt_pkg::IdxW'(1);
          next_off_q <= next_off_q + step;
          ph_q <= 1'b0;
        end
        S_FLUSH: begin
          if (!ph_q) ph_q <= 1'b1;
          else if (fire) begin
            done_q <= done_q + FW'(1);
            ph_q <= 1'b0;
          end else if (settle_now) begin
            ph_q <= 1'b0;
          end else if (!emit_ok) begin
            ph_q <= 1'b0;
            if (item_q.last_vertex) begin
              head_q <= '0;
              fill_q <= '0;
              done_q <= '0;
              next_off_q <= '0;
              cnt_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  ap_done_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= fill_q) else $error("emit count passed fill");
  ap_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_DEPTH)) else $error("window overfilled");
  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !out_ch.valid) else $error("accepting while emitting");
  ap_kcur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (kcur_q != '0)) else $error("zero marker length in use");

endmodule
